[hdl/dri_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and tables for the delta robot inverse kinematics block.
// No dependencies; every other file depends on this package.
package dri_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_FRAC   = 8;
  localparam int ANG_W        = ANGLE_FRAC + 9;
  localparam int PHI_W        = ANG_W + 1;
  localparam int CW           = 36;
  localparam int SQRT_STEPS   = 29;
  localparam int NORM_STEPS   = 5;
  localparam int STEP_W       = 5;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 14;

  // ceil(2^31 / 255) and ceil(2^21 / 80)
  localparam logic signed [31:0] RECIP255 = 32'sd8421505;
  localparam logic signed [31:0] RECIP80  = 32'sd26215;

  localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 << ANGLE_FRAC);
  localparam logic signed [PHI_W-1:0] PHI_LIM = PHI_W'(40 << ANGLE_FRAC);

  // atan(2^-i) in units of 1e-12 degree
  localparam longint unsigned ATAN_PICO [0:23] = '{
    64'd45000000000000, 64'd26565051177078, 64'd14036243467926, 64'd7125016348902,
    64'd3576334374997,  64'd1789910608246,  64'd895173710211,   64'd447614170861,
    64'd223810500369,   64'd111905677066,   64'd55952891894,    64'd27976452617,
    64'd13988227142,    64'd6994113675,     64'd3497056851,     64'd1748528427,
    64'd874264214,      64'd437132107,      64'd218566053,      64'd109283027,
    64'd54641513,       64'd27320757,       64'd13660378,       64'd6830189
  };

  function automatic logic [ANG_W-1:0] atan_entry(input int idx);
    longint unsigned t;
    t = ATAN_PICO[idx];
    return ANG_W'(((t << ANGLE_FRAC) + 64'd500000000000) / 64'd1000000000000);
  endfunction

  localparam logic [ANG_W-1:0] ATAN_TAB [0:23] = '{
    atan_entry(0),  atan_entry(1),  atan_entry(2),  atan_entry(3),
    atan_entry(4),  atan_entry(5),  atan_entry(6),  atan_entry(7),
    atan_entry(8),  atan_entry(9),  atan_entry(10), atan_entry(11),
    atan_entry(12), atan_entry(13), atan_entry(14), atan_entry(15),
    atan_entry(16), atan_entry(17), atan_entry(18), atan_entry(19),
    atan_entry(20), atan_entry(21), atan_entry(22), atan_entry(23)
  };

  localparam logic signed [17:0] COS_Q16 [0:2] = '{18'sd65536, -18'sd32768, -18'sd32768};
  localparam logic signed [17:0] SIN_Q16 [0:2] = '{18'sd0, 18'sd56756, -18'sd56756};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER_ARM,
    REG_FOREARM,
    REG_RADIUS_DIFF,
    REG_Z_LOWEST,
    REG_Z_HIGHEST,
    REG_SERVO_LOWEST,
    REG_SERVO_HIGHEST
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_CAPTURE,
    OP_MAP_X_MUL, OP_MAP_X_DIV, OP_MAP_Y_MUL, OP_MAP_Y_DIV, OP_MAP_Z_MUL, OP_MAP_Z_DIV,
    OP_CR_MUL, OP_CR_ADD, OP_CT_MUL, OP_CT_SUB,
    OP_B2_MUL, OP_B2_SUB, OP_C2_MUL, OP_C2_ADD, OP_A2_MUL,
    OP_NUM, OP_DEN, OP_NSQ, OP_SQRT_INIT, OP_SQRT_STEP,
    OP_LOAD_ALPHA, OP_NORM, OP_QUAD, OP_ITER, OP_LOAD_BETA,
    OP_PHI, OP_SERVO_MUL, OP_SERVO_DIV, OP_FLAG_BAD, OP_LOAD_OUT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MXM, ST_MXD, ST_MYM, ST_MYD, ST_MZM, ST_MZD,
    ST_CRM, ST_CRA, ST_CTM, ST_CTS, ST_B2M, ST_B2S, ST_C2M, ST_C2A, ST_A2M,
    ST_NUM, ST_DEN, ST_NSQ, ST_SQI, ST_SQS,
    ST_LA, ST_NORM, ST_QUAD, ST_ITER, ST_LB,
    ST_PHI, ST_SVM, ST_SVD, ST_BAD, ST_DONE
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [1:0]        arm;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic unreachable;
    logic too_far;
  } status_t;

endpackage

[hdl/dri_if.sv]
`timescale 1ns / 1ps
// Handshake channels of the inverse kinematics block: targets, servo commands, config.
// Depends on dri_pkg for the config widths.
interface dri_target_if;
  logic       valid;
  logic       ready;
  logic [7:0] target_x;
  logic [7:0] target_y;
  logic [7:0] target_z;
  modport source (output valid, target_x, target_y, target_z, input ready);
  modport sink (input valid, target_x, target_y, target_z, output ready);
endinterface

interface dri_servo_if;
  logic       valid;
  logic       ready;
  logic [7:0] servo_arm0;
  logic [7:0] servo_arm1;
  logic [7:0] servo_arm2;
  logic       unreachable_arm0;
  logic       unreachable_arm1;
  logic       unreachable_arm2;
  modport source (output valid, servo_arm0, servo_arm1, servo_arm2,
                  unreachable_arm0, unreachable_arm1, unreachable_arm2, input ready);
  modport sink (input valid, servo_arm0, servo_arm1, servo_arm2,
                unreachable_arm0, unreachable_arm1, unreachable_arm2, output ready);
endinterface

interface dri_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dri_pkg::CFG_IDX_W-1:0]  index;
  logic [dri_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/dri_ctl.sv]
`timescale 1ns / 1ps
// Sequencer for the inverse kinematics datapath: one command per cycle, arm and step counters.
// Depends on dri_pkg.
module dri_ctl import dri_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    out_ready,
  output logic    out_valid,
  input  status_t status,
  output cmd_t    cmd
);

  state_t            state, state_next;
  logic [1:0]        arm, arm_next;
  logic [STEP_W-1:0] step, step_next;
  logic              beta_phase, beta_phase_next;
  logic              out_pending, out_pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      arm         <= '0;
      step        <= '0;
      beta_phase  <= 1'b0;
      out_pending <= 1'b0;
    end else begin
      state       <= state_next;
      arm         <= arm_next;
      step        <= step_next;
      beta_phase  <= beta_phase_next;
      out_pending <= out_pending_next;
    end
  end

  assign out_valid = out_pending;

  always_comb begin
    state_next      = state;
    arm_next        = arm;
    step_next       = step;
    beta_phase_next = beta_phase;
    cmd.op          = OP_NOP;
    cmd.arm         = arm;
    cmd.step        = step;
    in_ready        = 1'b0;
    out_pending_next = out_pending & ~out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = ST_MXM;
        end
      end
      ST_MXM: begin cmd.op = OP_MAP_X_MUL; state_next = ST_MXD; end
      ST_MXD: begin cmd.op = OP_MAP_X_DIV; state_next = ST_MYM; end
      ST_MYM: begin cmd.op = OP_MAP_Y_MUL; state_next = ST_MYD; end
      ST_MYD: begin cmd.op = OP_MAP_Y_DIV; state_next = ST_MZM; end
      ST_MZM: begin cmd.op = OP_MAP_Z_MUL; state_next = ST_MZD; end
      ST_MZD: begin
        cmd.op     = OP_MAP_Z_DIV;
        arm_next   = '0;
        state_next = ST_CRM;
      end
      ST_CRM: begin cmd.op = OP_CR_MUL; state_next = ST_CRA; end
      ST_CRA: begin cmd.op = OP_CR_ADD; state_next = ST_CTM; end
      ST_CTM: begin cmd.op = OP_CT_MUL; state_next = ST_CTS; end
      ST_CTS: begin cmd.op = OP_CT_SUB; state_next = ST_B2M; end
      ST_B2M: begin cmd.op = OP_B2_MUL; state_next = ST_B2S; end
      ST_B2S: begin cmd.op = OP_B2_SUB; state_next = ST_C2M; end
      ST_C2M: begin cmd.op = OP_C2_MUL; state_next = ST_C2A; end
      ST_C2A: begin cmd.op = OP_C2_ADD; state_next = ST_A2M; end
      ST_A2M: begin cmd.op = OP_A2_MUL; state_next = ST_NUM; end
      ST_NUM: begin
        cmd.op     = OP_NUM;
        state_next = status.unreachable ? ST_BAD : ST_DEN;
      end
      ST_DEN: begin cmd.op = OP_DEN; state_next = ST_NSQ; end
      ST_NSQ: begin cmd.op = OP_NSQ; state_next = ST_SQI; end
      ST_SQI: begin
        if (status.too_far) begin
          state_next = ST_BAD;
        end else begin
          cmd.op     = OP_SQRT_INIT;
          step_next  = '0;
          state_next = ST_SQS;
        end
      end
      ST_SQS: begin
        cmd.op = OP_SQRT_STEP;
        if (step == STEP_W'(SQRT_STEPS - 1)) begin
          step_next  = '0;
          state_next = ST_LA;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_LA: begin
        cmd.op          = OP_LOAD_ALPHA;
        beta_phase_next = 1'b0;
        step_next       = '0;
        state_next      = ST_NORM;
      end
      ST_NORM: begin
        cmd.op = OP_NORM;
        if (step == STEP_W'(NORM_STEPS - 1)) begin
          step_next  = '0;
          state_next = ST_QUAD;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_QUAD: begin
        cmd.op     = OP_QUAD;
        step_next  = '0;
        state_next = ST_ITER;
      end
      ST_ITER: begin
        cmd.op = OP_ITER;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          step_next  = '0;
          state_next = beta_phase ? ST_PHI : ST_LB;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_LB: begin
        cmd.op          = OP_LOAD_BETA;
        beta_phase_next = 1'b1;
        step_next       = '0;
        state_next      = ST_NORM;
      end
      ST_PHI: begin cmd.op = OP_PHI; state_next = ST_SVM; end
      ST_SVM: begin cmd.op = OP_SERVO_MUL; state_next = ST_SVD; end
      ST_SVD, ST_BAD: begin
        cmd.op = (state == ST_SVD) ? OP_SERVO_DIV : OP_FLAG_BAD;
        // advance to the next arm, or finish after the third
        if (arm == 2'd2) begin
          state_next = ST_DONE;
        end else begin
          arm_next   = arm + 1'b1;
          state_next = ST_CRM;
        end
      end
      ST_DONE: begin
        if (!out_pending || out_ready) begin
          cmd.op           = OP_LOAD_OUT;
          out_pending_next = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[hdl/dri_dp.sv]
`timescale 1ns / 1ps
// Datapath: config registers, shared 32x32 multiplier, square root, CORDIC, servo mapping.
// Depends on dri_pkg; driven by commands from dri_ctl.
module dri_dp import dri_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [7:0]            target_x,
  input  logic [7:0]            target_y,
  input  logic [7:0]            target_z,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [7:0]            servo_arm0,
  output logic [7:0]            servo_arm1,
  output logic [7:0]            servo_arm2,
  output logic                  unreachable_arm0,
  output logic                  unreachable_arm1,
  output logic                  unreachable_arm2
);

  // configuration
  logic [12:0]        r_ua, r_fa;
  logic signed [13:0] r_rdiff, r_zlo, r_zhi;
  logic [7:0]         r_slo, r_shi;
  logic [7:0]         held [3];

  // working registers
  logic [7:0]              r_tx, r_ty, r_tz;
  logic [22:0]             r_p;
  logic                    r_neg;
  logic signed [11:0]      r_x, r_y;
  logic signed [13:0]      r_z;
  logic signed [39:0]      r_acc;
  logic signed [14:0]      r_cr;
  logic signed [12:0]      r_ct;
  logic signed [27:0]      r_b2;
  logic [27:0]             r_c2;
  logic [25:0]             r_a2;
  logic signed [29:0]      r_num;
  logic [57:0]             r_den, r_nsq, r_rad;
  logic [31:0]             r_rem;
  logic [28:0]             r_root;
  logic signed [CW-1:0]    r_cx, r_cy;
  logic signed [ANG_W-1:0] r_ang, r_alpha;
  logic [6:0]              r_deg;
  logic [2:0]              r_flag;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  // combinational helpers
  logic signed [12:0]      map_xy;
  logic signed [14:0]      z_off, z_sum;
  logic signed [39:0]      s_cr, s_ct;
  logic signed [15:0]      cr_sum;
  logic [33:0]             rem_sh, trial;
  logic [STEP_W-1:0]       norm_sh;
  logic [CW-1:0]           abs_x, abs_y, mx, norm_lim;
  logic signed [CW-1:0]    dx, dy;
  logic signed [PHI_W-1:0] phi, phi_c, phi_mag;
  logic [6:0]              ideg;
  logic signed [8:0]       servo_diff;
  logic [7:0]              servo_q, servo_cmd;

  assign status.unreachable = r_b2[27] | (r_c2 == '0) | (r_ua == '0);
  assign status.too_far     = r_nsq > r_den;

  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    servo_diff = $signed({1'b0, r_shi}) - $signed({1'b0, r_slo});
    unique case (cmd.op)
      OP_MAP_X_MUL: begin mul_a = 32'(r_tx); mul_b = 32'sd4000; end
      OP_MAP_Y_MUL: begin mul_a = 32'(r_ty); mul_b = 32'sd4000; end
      OP_MAP_Z_MUL: begin
        mul_a = 32'(r_tz);
        mul_b = 32'(15'(r_zhi) - 15'(r_zlo));
      end
      OP_MAP_X_DIV, OP_MAP_Y_DIV, OP_MAP_Z_DIV: begin
        mul_a = 32'(r_p);
        mul_b = RECIP255;
      end
      OP_CR_MUL: begin mul_a = 32'(r_x); mul_b = 32'(COS_Q16[cmd.arm]); end
      OP_CR_ADD: begin mul_a = 32'(r_y); mul_b = 32'(SIN_Q16[cmd.arm]); end
      OP_CT_MUL: begin mul_a = 32'(r_y); mul_b = 32'(COS_Q16[cmd.arm]); end
      OP_CT_SUB: begin mul_a = 32'(r_x); mul_b = 32'(SIN_Q16[cmd.arm]); end
      OP_B2_MUL: begin mul_a = 32'(r_fa); mul_b = 32'(r_fa); end
      OP_B2_SUB: begin mul_a = 32'(r_ct); mul_b = 32'(r_ct); end
      OP_C2_MUL: begin mul_a = 32'(r_cr); mul_b = 32'(r_cr); end
      OP_C2_ADD: begin mul_a = 32'(r_z); mul_b = 32'(r_z); end
      OP_A2_MUL: begin mul_a = 32'(r_ua); mul_b = 32'(r_ua); end
      OP_DEN:    begin mul_a = 32'(r_a2); mul_b = 32'(r_c2); end
      OP_NSQ:    begin mul_a = 32'(r_num); mul_b = 32'(r_num); end
      OP_SERVO_MUL: begin mul_a = 32'(r_deg); mul_b = 32'(servo_diff); end
      OP_SERVO_DIV: begin mul_a = 32'(r_p); mul_b = RECIP80; end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    map_xy  = $signed({1'b0, prod[42:31]}) - 13'sd2000;
    z_off   = r_neg ? -$signed({1'b0, prod[44:31]}) : $signed({1'b0, prod[44:31]});
    z_sum   = 15'(r_zlo) + z_off;
    s_cr    = r_acc + 40'(prod) + 40'sd32768;
    cr_sum  = $signed(s_cr[31:16]) + 16'(r_rdiff);
    s_ct    = r_acc - 40'(prod) + 40'sd32768;
    rem_sh  = {r_rem, r_rad[57:56]};
    trial   = {3'b000, r_root, 2'b01};
    norm_sh = STEP_W'(5'd16 >> cmd.step);
    abs_x   = r_cx[CW-1] ? CW'(-r_cx) : CW'(r_cx);
    abs_y   = r_cy[CW-1] ? CW'(-r_cy) : CW'(r_cy);
    mx      = (abs_x > abs_y) ? abs_x : abs_y;
    norm_lim = CW'(1) << (6'd31 - 6'(norm_sh));
    dx      = r_cy >>> cmd.step;
    dy      = r_cx >>> cmd.step;
    phi     = PHI_W'(r_ang) - PHI_W'(r_alpha);
    if (phi > PHI_LIM) begin
      phi_c = PHI_LIM;
    end else if (phi < -PHI_LIM) begin
      phi_c = -PHI_LIM;
    end else begin
      phi_c = phi;
    end
    phi_mag   = phi_c[PHI_W-1] ? -phi_c : phi_c;
    ideg      = 7'(phi_mag >>> ANGLE_FRAC);
    servo_q   = prod[28:21];
    servo_cmd = r_neg ? (r_slo - servo_q) : (r_slo + servo_q);
  end

  // configuration and held commands
  always_ff @(posedge clk) begin
    if (rst) begin
      r_ua    <= 13'd1000;
      r_fa    <= 13'd2000;
      r_rdiff <= 14'sd500;
      r_zlo   <= -14'sd2500;
      r_zhi   <= -14'sd1000;
      r_slo   <= 8'd0;
      r_shi   <= 8'd255;
      held[0] <= 8'd127;
      held[1] <= 8'd127;
      held[2] <= 8'd127;
    end else begin
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_UPPER_ARM:     r_ua    <= cfg_data[12:0];
          REG_FOREARM:       r_fa    <= cfg_data[12:0];
          REG_RADIUS_DIFF:   r_rdiff <= $signed(cfg_data);
          REG_Z_LOWEST:      r_zlo   <= $signed(cfg_data);
          REG_Z_HIGHEST:     r_zhi   <= $signed(cfg_data);
          REG_SERVO_LOWEST:  r_slo   <= cfg_data[7:0];
          REG_SERVO_HIGHEST: r_shi   <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_SERVO_DIV) begin
        held[cmd.arm] <= servo_cmd;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        r_tx <= target_x;
        r_ty <= target_y;
        r_tz <= target_z;
      end
      OP_MAP_X_MUL, OP_MAP_Y_MUL: r_p <= prod[22:0];
      OP_MAP_X_DIV: r_x <= map_xy[11:0];
      OP_MAP_Y_DIV: r_y <= map_xy[11:0];
      OP_MAP_Z_MUL, OP_SERVO_MUL: begin
        // keep sign and magnitude so the division truncates toward zero
        r_neg <= prod[63];
        r_p   <= prod[63] ? 23'(-prod) : prod[22:0];
      end
      OP_MAP_Z_DIV: r_z <= z_sum[13:0];
      OP_CR_MUL, OP_CT_MUL: r_acc <= 40'(prod);
      OP_CR_ADD: r_cr <= cr_sum[14:0];
      OP_CT_SUB: r_ct <= s_ct[28:16];
      OP_B2_MUL: r_b2 <= $signed(prod[27:0]);
      OP_B2_SUB: r_b2 <= r_b2 - $signed(prod[27:0]);
      OP_C2_MUL: r_c2 <= prod[27:0];
      OP_C2_ADD: r_c2 <= r_c2 + prod[27:0];
      OP_A2_MUL: r_a2 <= prod[25:0];
      OP_NUM:    r_num <= 30'(r_a2) + 30'(r_c2) - 30'(r_b2);
      OP_DEN:    r_den <= {prod[55:0], 2'b00};
      OP_NSQ:    r_nsq <= prod[57:0];
      OP_SQRT_INIT: begin
        r_rad  <= r_den - r_nsq;
        r_rem  <= '0;
        r_root <= '0;
      end
      OP_SQRT_STEP: begin
        r_rad <= {r_rad[55:0], 2'b00};
        if (rem_sh >= trial) begin
          r_rem  <= 32'(rem_sh - trial);
          r_root <= {r_root[27:0], 1'b1};
        end else begin
          r_rem  <= rem_sh[31:0];
          r_root <= {r_root[27:0], 1'b0};
        end
      end
      OP_LOAD_ALPHA: begin
        r_cx  <= CW'(r_cr);
        r_cy  <= CW'(r_z);
        r_ang <= '0;
      end
      OP_NORM: begin
        // scale up until the larger magnitude reaches 2^30
        if (mx < norm_lim) begin
          r_cx <= r_cx <<< norm_sh;
          r_cy <= r_cy <<< norm_sh;
        end
      end
      OP_QUAD: begin
        if (r_cx[CW-1]) begin
          if (!r_cy[CW-1]) begin
            r_cx  <= r_cy;
            r_cy  <= -r_cx;
            r_ang <= ANG_90;
          end else begin
            r_cx  <= -r_cy;
            r_cy  <= r_cx;
            r_ang <= -ANG_90;
          end
        end
      end
      OP_ITER: begin
        if (!r_cy[CW-1]) begin
          r_cx  <= r_cx + dx;
          r_cy  <= r_cy - dy;
          r_ang <= r_ang + $signed(ATAN_TAB[cmd.step]);
        end else begin
          r_cx  <= r_cx - dx;
          r_cy  <= r_cy + dy;
          r_ang <= r_ang - $signed(ATAN_TAB[cmd.step]);
        end
      end
      OP_LOAD_BETA: begin
        r_alpha <= r_ang;
        r_cx    <= CW'(r_num);
        r_cy    <= $signed(CW'(r_root));
        r_ang   <= '0;
      end
      OP_PHI: r_deg <= phi_c[PHI_W-1] ? (7'd40 - ideg) : (7'd40 + ideg);
      OP_SERVO_DIV: r_flag[cmd.arm] <= 1'b0;
      OP_FLAG_BAD:  r_flag[cmd.arm] <= 1'b1;
      OP_LOAD_OUT: begin
        servo_arm0       <= held[0];
        servo_arm1       <= held[1];
        servo_arm2       <= held[2];
        unreachable_arm0 <= r_flag[0];
        unreachable_arm1 <= r_flag[1];
        unreachable_arm2 <= r_flag[2];
      end
      default: ;
    endcase
  end

endmodule

[hdl/delta_robot_inverse_kinematics.sv]
`timescale 1ns / 1ps
// Top level of the delta robot inverse kinematics block: sequencer plus datapath.
// Depends on dri_pkg, dri_if, dri_ctl and dri_dp.
//
//  channel   role   payload
//  targets   sink   target_x, target_y, target_z (byte position)
//  commands  source servo_arm0..2, unreachable_arm0..2
//  cfg       sink   index (register), data (14 bits, always ready)
//
// Each request is worked through arm by arm; once its result is loaded, the
// next request can be taken in the following cycle. An unreachable arm
// skips the square root and both CORDIC passes.
// Per arm the work runs through the shared 32x32 multiplier, the 29-step
// square root and two 16-step CORDIC passes (each with 5 normalize steps).
// A finished result waits in the output register while the next request is
// taken. Reset is synchronous and restores config and the held commands (127).
module delta_robot_inverse_kinematics import dri_pkg::*; (
  input logic        clk,
  input logic        rst,
  dri_target_if.sink targets,
  dri_servo_if.source commands,
  dri_cfg_if.sink    cfg
);

  cmd_t    cmd;
  status_t status;

  assign cfg.ready = 1'b1;

  dri_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (targets.valid),
    .in_ready  (targets.ready),
    .out_ready (commands.ready),
    .out_valid (commands.valid),
    .status    (status),
    .cmd       (cmd)
  );

  dri_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .target_x         (targets.target_x),
    .target_y         (targets.target_y),
    .target_z         (targets.target_z),
    .cfg_write        (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .servo_arm0       (commands.servo_arm0),
    .servo_arm1       (commands.servo_arm1),
    .servo_arm2       (commands.servo_arm2),
    .unreachable_arm0 (commands.unreachable_arm0),
    .unreachable_arm1 (commands.unreachable_arm1),
    .unreachable_arm2 (commands.unreachable_arm2)
  );

endmodule

[tb/sv/tb_delta_robot_inverse_kinematics.sv]
`timescale 1ns / 1ps
// Testbench for delta_robot_inverse_kinematics: random and directed targets, config sweeps.
// Depends on dri_pkg and dri_if; a scoreboard class predicts servo commands.

class ik_scoreboard;
  typedef struct {
    logic [7:0] servo [3];
    logic       unreach [3];
  } ik_result_t;

  longint arm_a, arm_b, rdiff, zlo, zhi, slo, shi;
  logic [7:0] held [3];
  ik_result_t pending [$];
  int errors;

  function new();
    arm_a = 1000; arm_b = 2000; rdiff = 500; zlo = -2500; zhi = -1000;
    slo = 0; shi = 255;
    held[0] = 127; held[1] = 127; held[2] = 127;
    errors = 0;
  endfunction

  function void write_reg(dri_pkg::cfg_reg_t idx, logic [13:0] val);
    case (idx)
      dri_pkg::REG_UPPER_ARM:     arm_a = val[12:0];
      dri_pkg::REG_FOREARM:       arm_b = val[12:0];
      dri_pkg::REG_RADIUS_DIFF:   rdiff = longint'($signed(val));
      dri_pkg::REG_Z_LOWEST:      zlo = longint'($signed(val));
      dri_pkg::REG_Z_HIGHEST:     zhi = longint'($signed(val));
      dri_pkg::REG_SERVO_LOWEST:  slo = val[7:0];
      dri_pkg::REG_SERVO_HIGHEST: shi = val[7:0];
      default: ;
    endcase
  endfunction

  static function longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  static function longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  static function longint atan_step(int i);
    longint unsigned t;
    t = dri_pkg::ATAN_PICO[i];
    return longint'((t * (64'd1 << dri_pkg::ANGLE_FRAC) + 64'd500000000000)
                    / 64'd1000000000000);
  endfunction

  static function longint vector_angle(longint y, longint x);
    longint ang, t, ax, ay, mx, dx, dy;
    ang = 0;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    mx = ax > ay ? ax : ay;
    if (mx == 0) return 0;
    while (mx < (64'sd1 <<< 30)) begin
      x *= 2; y *= 2; mx *= 2;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; ang = 90 <<< dri_pkg::ANGLE_FRAC;
      end else begin
        t = x; x = -y; y = t; ang = -(90 <<< dri_pkg::ANGLE_FRAC);
      end
    end
    for (int i = 0; i < dri_pkg::CORDIC_STEPS; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; ang += atan_step(i);
      end else begin
        x -= dx; y += dy; ang -= atan_step(i);
      end
    end
    return ang;
  endfunction

  function void note_target(logic [7:0] tx, logic [7:0] ty, logic [7:0] tz);
    longint px, py, pz, cr, ct, b2, c2, num, den2, alpha, beta, phi, deg, cmd, lim;
    longint cq [3], sq [3];
    ik_result_t r;
    cq = '{65536, -32768, -32768};
    sq = '{0, 56756, -56756};
    lim = 40 <<< dri_pkg::ANGLE_FRAC;
    px = longint'(tx) * 4000 / 255 - 2000;
    py = longint'(ty) * 4000 / 255 - 2000;
    pz = longint'(tz) * (zhi - zlo) / 255 + zlo;
    for (int i = 0; i < 3; i++) begin
      cr = fshr(px * cq[i] + py * sq[i] + 32768, 16) + rdiff;
      ct = fshr(py * cq[i] - px * sq[i] + 32768, 16);
      b2 = arm_b * arm_b - ct * ct;
      c2 = cr * cr + pz * pz;
      r.unreach[i] = 1'b1;
      if (b2 >= 0 && c2 > 0 && arm_a > 0) begin
        num = arm_a * arm_a + c2 - b2;
        den2 = 4 * arm_a * arm_a * c2;
        if (num * num <= den2) begin
          alpha = vector_angle(pz, cr);
          beta = vector_angle(longint'(floor_sqrt(den2 - num * num)), num);
          phi = beta - alpha;
          if (phi > lim) phi = lim;
          if (phi < -lim) phi = -lim;
          deg = phi / (64'sd1 <<< dri_pkg::ANGLE_FRAC);
          cmd = (deg + 40) * (shi - slo) / 80 + slo;
          held[i] = cmd[7:0];
          r.unreach[i] = 1'b0;
        end
      end
      r.servo[i] = held[i];
    end
    pending.push_back(r);
  endfunction

  function void check_command(logic [7:0] s0, logic [7:0] s1, logic [7:0] s2,
                              logic u0, logic u1, logic u2);
    ik_result_t e;
    if (pending.size() == 0) begin
      $error("servo command with no target pending");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (s0 !== e.servo[0]) begin
      $error("servo_arm0 expected %0d actual %0d", e.servo[0], s0); errors++;
    end
    if (s1 !== e.servo[1]) begin
      $error("servo_arm1 expected %0d actual %0d", e.servo[1], s1); errors++;
    end
    if (s2 !== e.servo[2]) begin
      $error("servo_arm2 expected %0d actual %0d", e.servo[2], s2); errors++;
    end
    if (u0 !== e.unreach[0]) begin
      $error("unreachable_arm0 expected %0d actual %0d", e.unreach[0], u0); errors++;
    end
    if (u1 !== e.unreach[1]) begin
      $error("unreachable_arm1 expected %0d actual %0d", e.unreach[1], u1); errors++;
    end
    if (u2 !== e.unreach[2]) begin
      $error("unreachable_arm2 expected %0d actual %0d", e.unreach[2], u2); errors++;
    end
  endfunction
endclass

module tb_delta_robot_inverse_kinematics;
  import dri_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic idle_on = 1'b1;
  int cycles = 0;

  dri_target_if targets();
  dri_servo_if commands();
  dri_cfg_if cfg();

  ik_scoreboard sb = new();

  delta_robot_inverse_kinematics dut (
    .clk(clk), .rst(rst), .targets(targets.sink), .commands(commands.source), .cfg(cfg.sink)
  );

  always #5 clk = ~clk;

  // Sample outputs at the edge; the class sees values from before any update.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && commands.valid && commands.ready)
      sb.check_command(commands.servo_arm0, commands.servo_arm1, commands.servo_arm2,
                       commands.unreachable_arm0, commands.unreachable_arm1,
                       commands.unreachable_arm2);
    if (cycles > CYCLE_LIMIT) begin
      $display("delta_robot_inverse_kinematics test failed");
      $finish;
    end
  end

  // Receiver drops ready at random, in bursts, while idle_on is set.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      commands.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      commands.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      commands.ready <= 1'b0;
    end else begin
      commands.ready <= 1'b1;
    end
  end

  task automatic write_reg(cfg_reg_t idx, int val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= 14'(val);
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, 14'(val));
    cfg.valid <= 1'b0;
    // hold valid low for one edge before the next request
    @(posedge clk);
  endtask

  task automatic send_target(logic [7:0] tx, logic [7:0] ty, logic [7:0] tz);
    if (idle_on && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 4)) @(posedge clk);
    targets.valid <= 1'b1;
    targets.target_x <= tx;
    targets.target_y <= ty;
    targets.target_z <= tz;
    do @(posedge clk); while (!targets.ready);
    sb.note_target(tx, ty, tz);
    targets.valid <= 1'b0;
    // hold valid low for one edge before the next request
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_geometry(int a, int b, int d, int zl, int zh, int sl, int sh);
    drain();
    write_reg(REG_UPPER_ARM, a);
    write_reg(REG_FOREARM, b);
    write_reg(REG_RADIUS_DIFF, d);
    write_reg(REG_Z_LOWEST, zl);
    write_reg(REG_Z_HIGHEST, zh);
    write_reg(REG_SERVO_LOWEST, sl);
    write_reg(REG_SERVO_HIGHEST, sh);
  endtask

  task automatic random_targets(int n);
    for (int i = 0; i < n; i++)
      send_target(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    targets.valid = 1'b0;
    targets.target_x = '0;
    targets.target_y = '0;
    targets.target_z = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corners, center, reversed and degenerate geometry.
    send_target(8'd128, 8'd128, 8'd128);
    send_target(8'd0, 8'd0, 8'd0);
    send_target(8'd255, 8'd255, 8'd255);
    send_target(8'd0, 8'd255, 8'd0);
    send_target(8'd255, 8'd0, 8'd255);
    send_target(8'd127, 8'd127, 8'd0);
    // Zero upper arm: every arm holds.
    set_geometry(0, 2000, 500, -2500, -1000, 0, 255);
    send_target(8'd10, 8'd200, 8'd90);
    // Short forearm: cannot reach.
    set_geometry(1000, 1, 500, -2500, -1000, 0, 255);
    send_target(8'd0, 8'd0, 8'd0);
    send_target(8'd127, 8'd128, 8'd5);
    // Zero distance: D zero, z range at zero, target at center.
    set_geometry(1000, 2000, 0, 0, 0, 0, 255);
    send_target(8'd127, 8'd127, 8'd127);
    send_target(8'd128, 8'd128, 8'd0);
    // Reversed ranges and extremes.
    set_geometry(8000, 8000, -8000, 8000, -8000, 255, 0);
    send_target(8'd0, 8'd0, 8'd0);
    send_target(8'd255, 8'd255, 8'd255);
    send_target(8'd60, 8'd190, 8'd128);
    set_geometry(1, 8000, 8000, -8000, 8000, 255, 255);
    send_target(8'd255, 8'd0, 8'd128);

    set_geometry(1000, 2000, 500, -2500, -1000, 0, 255);
    random_targets(150);
    // Let everything drain before the next request.
    while (sb.pending.size() != 0) @(posedge clk);
    random_targets(50);
    set_geometry(1500, 2500, 300, -3000, -500, 20, 230);
    random_targets(150);
    set_geometry($urandom_range(1, 8000), $urandom_range(1, 8000),
                 $urandom_range(0, 16000) - 8000, $urandom_range(0, 16000) - 8000,
                 $urandom_range(0, 16000) - 8000, $urandom_range(0, 255),
                 $urandom_range(0, 255));
    random_targets(100);
    set_geometry(700, 1800, -200, -2200, -800, 255, 0);
    idle_on <= 1'b0;
    random_targets(150);
    drain();
    if (sb.errors == 0) begin
      $display("delta_robot_inverse_kinematics test passed");
    end else begin
      $display("delta_robot_inverse_kinematics test failed");
    end
    $finish;
  end
endmodule
